// ===== hdl/f32rcp_pkg.sv =====
// Shared constants, stage carry type and table generation for the float32 reciprocal core.
// No dependencies; the core refers to items here by f32rcp_pkg:: scoped names.
`default_nettype none

package f32rcp_pkg;

    localparam logic [7:0]  EXP_ALL_ONES = 8'hff;
    localparam logic [9:0]  EXP_BIAS     = 10'd127;
    localparam logic [31:0] NAN_WORD     = 32'hffff_ffff;
    localparam int          EXT_BITS     = 50;   // 24 bit mantissa plus 26 low guard bits

    // Fields that ride alongside the arithmetic down the pipe
    typedef struct packed {
        logic        spec;       // special input, word below is final
        logic [31:0] spec_word;
        logic        sign;
        logic [7:0]  ex;
    } carry_t;

    // Double to single, round to nearest even; table values are always normal
    function automatic logic [31:0] to_f32(input real r);
        logic [63:0] bits;
        logic [52:0] m53;
        logic [24:0] m25;
        logic [10:0] e11;
        logic        up;
        bits = $realtobits(r);
        m53  = {1'b1, bits[51:0]};
        up   = m53[28] & ((|m53[27:0]) | m53[29]);
        m25  = {1'b0, m53[52:29]} + {24'd0, up};
        e11  = bits[62:52] - 11'd896;
        if (m25[24])
        begin
            m25 = m25 >> 1;
            e11 = e11 + 11'd1;
        end
        return {bits[63], e11[7:0], m25[22:0]};
    endfunction

    // {slope, offset} for one table entry, from u = 1/t and v = 1/(t + step)
    function automatic logic [63:0] table_entry(input real u, input real v);
        real av;
        real s;
        real bv;
        av   = (-u) * v;
        s    = $sqrt(u) + $sqrt(v);
        bv   = 0.5 * (s * s);
        return {to_f32(av), to_f32(bv)};
    endfunction

endpackage

`default_nettype wire

// ===== hdl/float32_reciprocal_core.sv =====
// Top level: pipelined float32 reciprocal, table slope/offset then a*m + b in single precision.
// Depends on f32rcp_pkg (carry type, constants, table generation).
//
//  port             dir  width  role
//  start            in   1      word valid, taken when busy is low
//  operand_bits     in   32     input word
//  busy             out  1      always low, a word may enter every cycle
//  done             out  1      result strobe, one cycle per word
//  reciprocal_bits  out  32     result word
//
// Eight register stages: table read, multiply, product round, align, add,
// leading-one search, normalize shift, round and exponent fix.
// done is registered alongside the result, down the valid chain v1 to v7; one word per cycle sustained.
// rst_n clears only the valid bits; the table is a constant ROM.
// The receiver cannot stall, so the pipe never holds.
`default_nettype none

module float32_reciprocal_core #(
    parameter int INDEX_BITS = 11
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [31:0] operand_bits,
    output logic             busy,
    output logic             done,
    output logic [31:0]      reciprocal_bits
);

    localparam int TABLE_DEPTH = 1 << INDEX_BITS;
    localparam int EXT = f32rcp_pkg::EXT_BITS;
    localparam real STEP = 1.0 / real'(TABLE_DEPTH);

    logic [63:0] rom_data [TABLE_DEPTH];

    for (genvar k = 0; k < TABLE_DEPTH; k++)
    begin : g_rom
        localparam real T = 1.0 + real'(k) * STEP;
        localparam real U = 1.0 / T;
        localparam real V = 1.0 / (T + STEP);
        assign rom_data[k] = f32rcp_pkg::table_entry(U, V);
    end

    // valid bits
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg, done_reg;

    f32rcp_pkg::carry_t c1_reg, c2_reg, c3_reg, c4_reg, c5_reg, c6_reg, c7_reg;
    f32rcp_pkg::carry_t c1_next;

    // stage 1
    logic [22:0] frac1_reg;
    logic [63:0] tab1_reg;
    logic [INDEX_BITS-1:0] idx;

    // stage 2
    logic [47:0] prod2_reg;
    logic [7:0]  pe2_reg;
    logic        ps2_reg;
    logic [31:0] off2_reg;

    // stage 3
    logic [23:0] pm3_reg;
    logic [7:0]  pe3_reg;
    logic        ps3_reg;
    logic [31:0] off3_reg;

    // stage 4
    logic [EXT-1:0] big4_reg, small4_reg;
    logic [7:0]     e4_reg;
    logic           sub4_reg;

    // stage 5
    logic [EXT:0]   sum5_reg;
    logic [7:0]     e5_reg;

    // stage 6
    logic [EXT:0]   sum6_reg;
    logic [5:0]     pos6_reg;
    logic [7:0]     e6_reg;
    logic           nz6_reg;

    // stage 7
    logic [EXT:0]   norm7_reg;
    logic [9:0]     e7_reg;
    logic           nz7_reg;

    logic [31:0]    result_reg;

    // ---------------- stage 1: classify and table read
    assign idx = operand_bits[22 -: INDEX_BITS];

    always_comb
    begin
        c1_next.sign      = operand_bits[31];
        c1_next.ex        = operand_bits[30:23];
        c1_next.spec      = 1'b0;
        c1_next.spec_word = {operand_bits[31], 31'd0};
        if (operand_bits[30:23] == f32rcp_pkg::EXP_ALL_ONES)
        begin
            c1_next.spec = 1'b1;
            if (operand_bits[22:0] != 23'd0)
            begin
                c1_next.spec_word = f32rcp_pkg::NAN_WORD;
            end
        end
        else if (operand_bits[30:23] == 8'd0)
        begin
            c1_next.spec      = 1'b1;
            c1_next.spec_word = {operand_bits[31], f32rcp_pkg::EXP_ALL_ONES, 23'd0};
        end
    end

    always_ff @(posedge clk)
    begin
        c1_reg    <= c1_next;
        frac1_reg <= operand_bits[22:0];
        tab1_reg  <= rom_data[idx];
    end

    // ---------------- stage 2: mantissa multiply
    always_ff @(posedge clk)
    begin
        c2_reg    <= c1_reg;
        prod2_reg <= {1'b1, tab1_reg[54:32]} * {1'b1, frac1_reg};
        pe2_reg   <= tab1_reg[62:55];
        ps2_reg   <= tab1_reg[63];
        off2_reg  <= tab1_reg[31:0];
    end

    // ---------------- stage 3: round product
    logic [23:0] pm_raw;
    logic        pg, pst, pup;
    logic [24:0] pm25;
    logic [7:0]  pe_next;
    logic [23:0] pm_next;

    always_comb
    begin
        if (prod2_reg[47])
        begin
            pm_raw = prod2_reg[47:24];
            pg     = prod2_reg[23];
            pst    = |prod2_reg[22:0];
        end
        else
        begin
            pm_raw = prod2_reg[46:23];
            pg     = prod2_reg[22];
            pst    = |prod2_reg[21:0];
        end
        pup     = pg & (pst | pm_raw[0]);
        pm25    = {1'b0, pm_raw} + {24'd0, pup};
        pe_next = pe2_reg + {7'd0, prod2_reg[47]};
        pm_next = pm25[23:0];
        if (pm25[24])
        begin
            pm_next = pm25[24:1];
            pe_next = pe_next + 8'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        c3_reg   <= c2_reg;
        pm3_reg  <= pm_next;
        pe3_reg  <= pe_next;
        ps3_reg  <= ps2_reg;
        off3_reg <= off2_reg;
    end

    // ---------------- stage 4: order operands and align the smaller
    logic           prod_big;
    logic [23:0]    big_m, small_m;
    logic [7:0]     big_e, small_e, ediff;
    logic [5:0]     sa;
    logic [EXT-1:0] small_full, small_sh;
    logic           lost;

    always_comb
    begin
        prod_big = {pe3_reg, pm3_reg[22:0]} > off3_reg[30:0];
        if (prod_big)
        begin
            big_m   = pm3_reg;
            big_e   = pe3_reg;
            small_m = {1'b1, off3_reg[22:0]};
            small_e = off3_reg[30:23];
        end
        else
        begin
            big_m   = {1'b1, off3_reg[22:0]};
            big_e   = off3_reg[30:23];
            small_m = pm3_reg;
            small_e = pe3_reg;
        end
        ediff      = big_e - small_e;
        sa         = (ediff > 8'(EXT + 1)) ? 6'(EXT + 1) : ediff[5:0];
        small_full = {small_m, {(EXT-24){1'b0}}};
        small_sh   = small_full >> sa;
        lost       = (small_sh << sa) != small_full;
    end

    always_ff @(posedge clk)
    begin
        c4_reg     <= c3_reg;
        big4_reg   <= {big_m, {(EXT-24){1'b0}}};
        small4_reg <= small_sh | {{(EXT-1){1'b0}}, lost};
        e4_reg     <= big_e;
        sub4_reg   <= ps3_reg ^ off3_reg[31];
    end

    // ---------------- stage 5: add or subtract
    always_ff @(posedge clk)
    begin
        c5_reg   <= c4_reg;
        e5_reg   <= e4_reg;
        sum5_reg <= sub4_reg ? ({1'b0, big4_reg} - {1'b0, small4_reg})
                             : ({1'b0, big4_reg} + {1'b0, small4_reg});
    end

    // ---------------- stage 6: leading one search
    logic [5:0] pos_next;

    always_comb
    begin
        pos_next = 6'd0;
        for (int i = 0; i <= EXT; i++)
        begin
            if (sum5_reg[i])
            begin
                pos_next = 6'(i);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        c6_reg   <= c5_reg;
        sum6_reg <= sum5_reg;
        pos6_reg <= pos_next;
        e6_reg   <= e5_reg;
        nz6_reg  <= |sum5_reg;
    end

    // ---------------- stage 7: normalize so the leading one sits at the top
    always_ff @(posedge clk)
    begin
        c7_reg    <= c6_reg;
        norm7_reg <= sum6_reg << (6'(EXT) - pos6_reg);
        e7_reg    <= {2'b0, e6_reg} + {4'd0, pos6_reg} - 10'(EXT - 1);
        nz7_reg   <= nz6_reg;
    end

    // ---------------- stage 8: round sum, rebias exponent, format
    logic [23:0] sm_raw;
    logic        sup;
    logic [24:0] sm25;
    logic [9:0]  se;
    logic [22:0] rfrac;
    logic [7:0]  rexp;
    logic [9:0]  ediff_out;
    logic [7:0]  oexp;
    logic [31:0] result_next;

    always_comb
    begin
        sm_raw = norm7_reg[EXT -: 24];
        sup    = norm7_reg[EXT-24] & ((|norm7_reg[EXT-25:0]) | sm_raw[0]);
        sm25   = {1'b0, sm_raw} + {24'd0, sup};
        se     = e7_reg;
        rfrac  = sm25[22:0];
        if (sm25[24])
        begin
            rfrac = sm25[23:1];
            se    = se + 10'd1;
        end
        rexp = se[7:0];
        if (!nz7_reg)
        begin
            rexp  = 8'd0;
            rfrac = 23'd0;
        end
        // field minus unbiased input exponent; negative sets the exponent field to zero
        ediff_out = {2'b0, rexp} + f32rcp_pkg::EXP_BIAS - {2'b0, c7_reg.ex};
        oexp      = ediff_out[9] ? 8'd0 : ediff_out[7:0];
        result_next = c7_reg.spec ? c7_reg.spec_word : {c7_reg.sign, oexp, rfrac};
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    // ---------------- valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            v5_reg   <= 1'b0;
            v6_reg   <= 1'b0;
            v7_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= start;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            v4_reg   <= v3_reg;
            v5_reg   <= v4_reg;
            v6_reg   <= v5_reg;
            v7_reg   <= v6_reg;
            done_reg <= v7_reg;
        end
    end

    assign busy            = 1'b0;
    assign done            = done_reg;
    assign reciprocal_bits = result_reg;

    // ---------------- checks
    a_done_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, 8))
        else $error("result strobe without a word 8 cycles earlier");

    a_nan_out: assert property (@(posedge clk) disable iff (!rst_n)
        (start && operand_bits[30:23] == f32rcp_pkg::EXP_ALL_ONES
         && operand_bits[22:0] != 23'd0) |-> ##8 (reciprocal_bits == f32rcp_pkg::NAN_WORD))
        else $error("NaN input did not give all ones");

    a_zero_out: assert property (@(posedge clk) disable iff (!rst_n)
        (start && operand_bits[30:23] == 8'd0)
        |-> ##8 (reciprocal_bits[30:23] == f32rcp_pkg::EXP_ALL_ONES
                 && reciprocal_bits[31] == $past(operand_bits[31], 8)))
        else $error("zero input did not give signed infinity");

    a_norm_top: assert property (@(posedge clk) disable iff (!rst_n)
        (v7_reg && nz7_reg) |-> norm7_reg[EXT])
        else $error("normalize stage left leading one off the top");

endmodule

`default_nettype wire
